[rtl/finder_pattern_run_scanner_core_macros.svh]
// Assertion macros shared by the finder pattern run scanner checker.
`ifndef FINDER_PATTERN_RUN_SCANNER_CORE_MACROS_SVH
`define FINDER_PATTERN_RUN_SCANNER_CORE_MACROS_SVH

// Check on every clock edge outside reset.
`define FPRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fprs: check failed");

// Check on every clock edge, reset included.
`define FPRS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fprs: reset check failed");

`endif

[rtl/fprs_pkg.sv]
// Shared constants and types of the finder pattern run scanner.
package fprs_pkg;

  // Default coordinate width and growth of a five-run sum over it
  localparam int COORD_BITS_DEF = 12;
  localparam int SUM_GROW       = 3;

  // Fraction bits register
  localparam int             FRAC_W     = 5;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd21;
  localparam int             FRAC_N     = 1 << FRAC_W;

  // floor(2^f / 7) for the largest shift fits in this many bits
  localparam int RECIP_W = 29;

  // Run ring: five runs, the middle one is the 3-module dark core
  localparam int NUM_RUNS = 5;
  localparam int MID_RUN  = 2;

  // Per-cell control for one pixel transfer
  typedef struct packed {
    logic en;     // pixel transfer this cycle
    logic clear;  // line start: runs read as zero
    logic shift;  // colour change: take neighbor's run
    logic grow;   // head cell: grow run on same colour
  } cell_ctl_t;

endpackage

[rtl/fprs_run_cell.sv]
// One run length cell of the shifting run chain.
module fprs_run_cell import fprs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cell_ctl_t                          ctl,
  input  logic [COORD_BITS-1:0]              shift_in,
  input  logic [COORD_BITS+SUM_GROW-1:0]     sum_in,
  output logic [COORD_BITS-1:0]              run_eff,
  output logic [COORD_BITS+SUM_GROW-1:0]     sum_out
);

  localparam logic [COORD_BITS-1:0] RUN_MAX = {COORD_BITS{1'b1}};

  logic [COORD_BITS-1:0] run_r;
  logic [COORD_BITS-1:0] run_nxt;

  // Run as seen by this pixel: zero on a line start
  assign run_eff = ctl.clear ? '0 : run_r;
  assign sum_out = sum_in + (COORD_BITS+SUM_GROW)'(run_eff);

  // Shift on colour change, saturating growth in the head cell
  always_comb begin
    run_nxt = run_r;
    if (ctl.en) begin
      if (ctl.shift) begin
        run_nxt = shift_in;
      end else if (ctl.grow && run_eff != RUN_MAX) begin
        run_nxt = COORD_BITS'(run_eff + 1'b1);
      end else begin
        run_nxt = run_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else begin
      run_r <= run_nxt;
    end
  end

endmodule

[rtl/fprs_ratio.sv]
// Pipelined 1:1:3:1:1 ratio check with half-module tolerance in fixed point.
module fprs_ratio import fprs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_vld,
  input  logic [COORD_BITS-1:0]          in_runs [NUM_RUNS],
  input  logic [COORD_BITS+SUM_GROW-1:0] in_sum,
  input  logic [3*COORD_BITS:0]          in_seg,
  input  logic [FRAC_W-1:0]              frac,
  output logic                           out_vld,
  output logic [3*COORD_BITS:0]          out_seg
);

  localparam int SW  = COORD_BITS + SUM_GROW;   // run sum
  localparam int XW  = SW + 2;                  // sum times 2^f mod 7
  localparam int NSH = XW + 3;                  // reciprocal shift for /7
  localparam int KW  = NSH - 2;
  localparam int QW  = XW + KW;
  localparam logic [KW-1:0] K_SEVEN = KW'(((64'd1 << NSH) + 64'd6) / 64'd7);
  localparam int BW  = SW + RECIP_W;            // base = (sum << f) / 7
  localparam int CW  = BW + 1;                  // bounds and shifted runs
  localparam int GW  = 3 * COORD_BITS + 1;

  // 2^f = 7*m + 2^(f mod 3): m and the small shift, per f
  logic [RECIP_W-1:0] m_tab  [FRAC_N];
  logic [1:0]         sh_tab [FRAC_N];
  for (genvar g = 0; g < FRAC_N; g++) begin : g_tab
    assign m_tab[g]  = RECIP_W'((64'd1 << g) / 64'd7);
    assign sh_tab[g] = 2'(g % 3);
  end

  // Stage A: captured snapshot
  logic                  a_vld_r;
  logic [COORD_BITS-1:0] a_runs_r [NUM_RUNS];
  logic [SW-1:0]         a_sum_r;
  logic [GW-1:0]         a_seg_r;
  // Stage B: partial quotients
  logic                  b_vld_r;
  logic [COORD_BITS-1:0] b_runs_r [NUM_RUNS];
  logic [BW-1:0]         b_prod_r;
  logic [SW-1:0]         b_rem_r;
  logic [GW-1:0]         b_seg_r;
  // Stage C: base
  logic                  c_vld_r;
  logic [COORD_BITS-1:0] c_runs_r [NUM_RUNS];
  logic [BW-1:0]         c_base_r;
  logic [GW-1:0]         c_seg_r;
  // Stage D: tolerance windows
  logic                  d_vld_r;
  logic [COORD_BITS-1:0] d_runs_r [NUM_RUNS];
  logic [CW-1:0]         d_lo1_r, d_hi1_r, d_lo3_r, d_hi3_r;
  logic [GW-1:0]         d_seg_r;
  // Output register
  logic                  out_vld_r;
  logic [GW-1:0]         out_seg_r;

  logic [XW-1:0] x_small;
  logic [QW-1:0] q_full;
  logic [CW-1:0] base_w, half_w, tri_w;
  logic [NUM_RUNS-1:0] run_ok;

  // Remainder part: floor(sum * 2^(f mod 3) / 7) by reciprocal multiply
  assign x_small = XW'(a_sum_r) << sh_tab[frac];
  assign q_full  = QW'(x_small) * QW'(K_SEVEN);

  // Windows around base and 3*base
  assign base_w = CW'(c_base_r);
  assign half_w = CW'(c_base_r >> 1);
  assign tri_w  = (base_w << 1) + base_w;

  // Per-run window compare against the shifted run
  always_comb begin
    logic [CW-1:0] t;
    for (int k = 0; k < NUM_RUNS; k++) begin
      t = CW'(d_runs_r[k]) << frac;
      if (k == MID_RUN) begin
        run_ok[k] = (t >= d_lo3_r) && (t <= d_hi3_r);
      end else begin
        run_ok[k] = (t >= d_lo1_r) && (t <= d_hi1_r);
      end
    end
  end

  // Valid bits, frozen while the output is back-pressured
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r   <= in_vld;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      d_vld_r   <= c_vld_r;
      out_vld_r <= d_vld_r && (&run_ok);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      a_runs_r  <= in_runs;
      a_sum_r   <= in_sum;
      a_seg_r   <= in_seg;

      b_runs_r  <= a_runs_r;
      b_prod_r  <= BW'(a_sum_r) * BW'(m_tab[frac]);
      b_rem_r   <= SW'(q_full >> NSH);
      b_seg_r   <= a_seg_r;

      c_runs_r  <= b_runs_r;
      c_base_r  <= b_prod_r + BW'(b_rem_r);
      c_seg_r   <= b_seg_r;

      d_runs_r  <= c_runs_r;
      d_lo1_r   <= base_w - half_w;
      d_hi1_r   <= base_w + half_w;
      d_lo3_r   <= tri_w - half_w;
      d_hi3_r   <= tri_w + half_w;
      d_seg_r   <= c_seg_r;

      out_seg_r <= d_seg_r;
    end
  end

  assign out_vld = out_vld_r;
  assign out_seg = out_seg_r;

endmodule

[rtl/finder_pattern_run_scanner_core.sv]
// Top level of the finder pattern run scanner.
// Takes one binarized pixel per clock and keeps the five latest run lengths in a
// chain of run cells that shift on each colour change. On a dark-to-light change
// the five runs are checked against 1:1:3:1:1 with a half-module tolerance, using
// cfg_wdata fraction bits, and a match yields one segment (start, end, line,
// direction) through the check stages A to D and then the output register.
// Throughput is one pixel per cycle while not stalled; a result held in the output
// register under out_stall freezes the check pipeline and stalls the input.
// Write the fraction bits only while no pixels are in flight.
module finder_pattern_run_scanner_core import fprs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_pixel,
  input  logic                  in_line_start,
  input  logic                  in_vertical,
  input  logic [COORD_BITS-1:0] in_position,
  input  logic [COORD_BITS-1:0] in_line_index,
  // segment channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_start_pos,
  output logic [COORD_BITS-1:0] out_end_pos,
  output logic [COORD_BITS-1:0] out_line_out,
  output logic                  out_vertical_out,
  // configuration
  input  logic                  cfg_we,
  input  logic [FRAC_W-1:0]     cfg_wdata
);

  localparam int SW = COORD_BITS + SUM_GROW;
  localparam int GW = 3 * COORD_BITS + 1;

  logic [FRAC_W-1:0]     frac_r;
  logic                  last_colour_r;
  logic                  adv;
  logic                  accept;
  logic                  change;
  logic                  hit;
  logic [COORD_BITS-1:0] eff   [NUM_RUNS];
  logic [SW-1:0]         sum_c [NUM_RUNS+1];
  logic [COORD_BITS-1:0] start_pos;
  logic [COORD_BITS-1:0] end_pos;
  logic [GW-1:0]         seg;
  logic [GW-1:0]         out_seg;

  // Pipeline moves unless a result waits in the output register
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign change   = in_pixel != last_colour_r;

  // Configuration and last colour
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r        <= FRAC_RESET;
      last_colour_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        frac_r <= cfg_wdata;
      end
      if (accept) begin
        last_colour_r <= in_pixel;
      end
    end
  end

  // Run chain: cell 0 holds the current run, the last cell the oldest
  assign sum_c[0] = '0;
  for (genvar i = 0; i < NUM_RUNS; i++) begin : g_cell
    cell_ctl_t             ctl;
    logic [COORD_BITS-1:0] nb;
    if (i == 0) begin : g_head
      assign nb = COORD_BITS'(1);
    end else begin : g_body
      assign nb = eff[i-1];
    end
    assign ctl.en    = accept;
    assign ctl.clear = in_line_start;
    assign ctl.shift = change;
    assign ctl.grow  = (i == 0);
    fprs_run_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .shift_in (nb),
      .sum_in   (sum_c[i]),
      .run_eff  (eff[i]),
      .sum_out  (sum_c[i+1])
    );
  end

  // Candidate: dark-to-light change with nonempty runs
  assign hit       = accept && change && !in_pixel && (sum_c[NUM_RUNS] != '0);
  assign start_pos = in_position - sum_c[NUM_RUNS][COORD_BITS-1:0];
  assign end_pos   = in_position - COORD_BITS'(1);
  assign seg       = {in_vertical, in_line_index, end_pos, start_pos};

  fprs_ratio #(.COORD_BITS(COORD_BITS)) u_ratio (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (hit),
    .in_runs (eff),
    .in_sum  (sum_c[NUM_RUNS]),
    .in_seg  (seg),
    .frac    (frac_r),
    .out_vld (out_valid),
    .out_seg (out_seg)
  );

  assign out_start_pos    = out_seg[COORD_BITS-1:0];
  assign out_end_pos      = out_seg[2*COORD_BITS-1:COORD_BITS];
  assign out_line_out     = out_seg[3*COORD_BITS-1:2*COORD_BITS];
  assign out_vertical_out = out_seg[3*COORD_BITS];

endmodule

[rtl/fprs_checker.sv]
// Port-level checks of the finder pattern run scanner, bound to the top level.
`include "finder_pattern_run_scanner_core_macros.svh"

module fprs_checker import fprs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_start_pos,
  input logic [COORD_BITS-1:0] out_end_pos,
  input logic [COORD_BITS-1:0] out_line_out,
  input logic                  out_vertical_out
);

  // Input backs up only behind a waiting result
  `FPRS_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall))

  // A stalled result holds
  `FPRS_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_start_pos) && $stable(out_end_pos) && $stable(out_line_out) && $stable(out_vertical_out)))

  // Reset empties the output and releases the input
  `FPRS_ASSERT_ALWAYS(a_reset_clean, !rst_n |=> (!out_valid && !in_stall))

endmodule

bind finder_pattern_run_scanner_core fprs_checker #(.COORD_BITS(COORD_BITS)) u_fprs_checker (.*);
